>>> rtl/core/wbps_pkg.sv
package wbps_pkg;

    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int LEN_M1_W  = 4;
    localparam int OFFSET_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_WILDCARD_BYTE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } out_word_t;

    typedef struct packed {
        logic                hit;
        logic                last;
        logic [LEN_M1_W-1:0] len_m1;
    } rec_t;

endpackage

>>> rtl/core/wbps_front.sv
module wbps_front #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  wbps_pkg::in_word_t                   in_word,
    input  logic [8*wbps_pkg::PAT_BYTES-1:0]     pattern,
    input  logic [wbps_pkg::LEN_W-1:0]           pattern_length,
    input  logic [7:0]                           wildcard_byte,
    output wbps_pkg::rec_t                       rec
);

    localparam int WD = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam logic [wbps_pkg::LEN_W-1:0] MAX_LEN = wbps_pkg::LEN_W'(MAX_PATTERN);
    localparam logic [wbps_pkg::LEN_M1_W-1:0] CNT_MAX = '1;

    logic [7:0]                    win_reg [WD];
    logic [wbps_pkg::LEN_M1_W-1:0] cnt_reg;
    logic [wbps_pkg::LEN_M1_W-1:0] cnt_next;
    logic [wbps_pkg::LEN_M1_W-1:0] len_m1;
    logic [7:0]                    cand   [MAX_PATTERN];
    logic [7:0]                    pat_b  [wbps_pkg::PAT_BYTES];
    logic                          all_ok;

    always_comb begin
        if (pattern_length == '0) begin
            len_m1 = '0;
        end else if (pattern_length > MAX_LEN) begin
            len_m1 = wbps_pkg::LEN_M1_W'(MAX_PATTERN - 1);
        end else begin
            len_m1 = wbps_pkg::LEN_M1_W'(pattern_length - 5'd1);
        end
    end

    always_comb begin
        for (int i = 0; i < wbps_pkg::PAT_BYTES; i++) begin
            pat_b[i] = pattern[8*i +: 8];
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            cand[k] = (k == 0) ? in_word.data_byte : win_reg[(k == 0) ? 0 : k - 1];
        end
    end

    always_comb begin
        logic [wbps_pkg::LEN_M1_W-1:0] j;
        logic [7:0]                    p;
        all_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            j = len_m1 - wbps_pkg::LEN_M1_W'(k);
            p = pat_b[j];
            if (wbps_pkg::LEN_M1_W'(k) <= len_m1 && p != wildcard_byte && cand[k] != p) begin
                all_ok = 1'b0;
            end
        end
    end

    assign rec.hit    = all_ok && (cnt_reg >= len_m1);
    assign rec.last   = in_word.last_byte;
    assign rec.len_m1 = len_m1;

    always_comb begin
        cnt_next = cnt_reg;
        if (push) begin
            if (in_word.last_byte) begin
                cnt_next = '0;
            end else if (cnt_reg != CNT_MAX) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            win_reg[0] <= in_word.data_byte;
            for (int k = 1; k < WD; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

endmodule

>>> rtl/core/wbps_queue.sv
module wbps_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  wbps_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output wbps_pkg::rec_t pop_rec
);

    wbps_pkg::rec_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_next;
    logic [1:0]     count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

>>> rtl/core/wbps_back.sv
module wbps_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rec_valid,
    input  wbps_pkg::rec_t        rec,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wbps_pkg::out_word_t   m_data
);

    localparam logic [wbps_pkg::OFFSET_W-1:0] COUNT_MAX = '1;

    logic [wbps_pkg::OFFSET_W-1:0] count_reg;
    logic [wbps_pkg::OFFSET_W-1:0] count_next;
    logic                          seen_reg;
    logic                          seen_next;
    logic [wbps_pkg::OFFSET_W-1:0] first_reg;
    logic [wbps_pkg::OFFSET_W-1:0] first_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    wbps_pkg::out_word_t           m_data_reg;
    wbps_pkg::out_word_t           m_data_next;
    logic                          seen_now;
    logic [wbps_pkg::OFFSET_W-1:0] first_now;

    assign pop = rec_valid && (!rec.last || !m_valid_reg || m_ready);

    always_comb begin
        seen_now  = seen_reg;
        first_now = first_reg;
        if (!seen_reg && rec.hit) begin
            seen_now  = 1'b1;
            first_now = count_reg - wbps_pkg::OFFSET_W'(rec.len_m1);
        end
    end

    always_comb begin
        count_next   = count_reg;
        seen_next    = seen_reg;
        first_next   = first_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (pop) begin
            if (rec.last) begin
                count_next   = '0;
                seen_next    = 1'b0;
                first_next   = '0;
                m_valid_next = 1'b1;
                m_data_next.found        = seen_now;
                m_data_next.match_offset = seen_now ? first_now : '0;
            end else begin
                seen_next  = seen_now;
                first_next = first_now;
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            seen_reg    <= 1'b0;
            first_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            seen_reg    <= seen_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner: feed a buffer one byte per word on s_, with last_byte set on
// its final byte, and one word per buffer comes out on m_ giving found and the start offset of
// the first match (0 when not found). The pattern (1 to MAX_PATTERN bytes, any byte equal to
// wildcard_byte matches anything) is set through cfg_we/cfg_index/cfg_wdata; write it only while
// the block is idle, which the block itself does not enforce. One byte is taken every cycle while
// the queue has room: the front compares the whole window combinationally, a two-entry queue
// decouples it from the offset tracker, and the result sits in an output register, so a new byte
// is accepted while a result waits; the last byte's record is registered in the queue, then in m_data.
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wbps_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output wbps_pkg::out_word_t                 m_data
);

    logic [63:0]                  pattern_low_reg;
    logic [63:0]                  pattern_high_reg;
    logic [wbps_pkg::LEN_W-1:0]   pattern_length_reg;
    logic [7:0]                   wildcard_byte_reg;
    logic                         push;
    logic                         full;
    logic                         pop;
    logic                         rec_valid;
    wbps_pkg::rec_t               front_rec;
    wbps_pkg::rec_t               back_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= wbps_pkg::LEN_W'(1);
            wildcard_byte_reg  <= '0;
        end else if (cfg_we) begin
            case (wbps_pkg::cfg_index_t'(cfg_index))
                wbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                wbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                wbps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[wbps_pkg::LEN_W-1:0];
                wbps_pkg::CFG_WILDCARD_BYTE:  wildcard_byte_reg  <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !full;
    assign push    = s_valid && s_ready;

    wbps_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (push),
        .in_word        (s_data),
        .pattern        ({pattern_high_reg, pattern_low_reg}),
        .pattern_length (pattern_length_reg),
        .wildcard_byte  (wildcard_byte_reg),
        .rec            (front_rec)
    );

    wbps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (front_rec),
        .full      (full),
        .pop       (pop),
        .not_empty (rec_valid),
        .pop_rec   (back_rec)
    );

    wbps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (back_rec),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
